@@ rtl/sls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_pkg: shared types and constants of the sticky route selector
// Word formats, command and status codes, and the back end state encoding.
// ----------------------------------------------------------------------------
package sls_pkg;

	localparam int MAX_ROUTES   = 8;
	localparam int ROUTE_W      = 3;
	localparam int COUNT_W      = 4;
	localparam int ESLS_W       = 7;
	localparam int ESLS_ENTRIES = 128;
	localparam int SHIFT_W      = 5;
	localparam int ESHIFT_W     = 3;
	localparam int ADDR_W       = 4;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;
	localparam logic [1:0] CMD_AVAIL  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_ABSENT  = 2'd2;

	localparam logic [1:0] REG_OPC_SHIFT  = 2'd0;
	localparam logic [1:0] REG_DPC_SHIFT  = 2'd1;
	localparam logic [1:0] REG_ESLS_SHIFT = 2'd2;

	localparam logic [5:0] SIX_MASK = 6'h3f;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [23:0] origin_code;
		logic [23:0] dest_code;
		logic [3:0]  link_selection;
		logic [2:0]  route_id;
		logic        route_up;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       route_found;
		logic [2:0] chosen_route;
		logic       via_alternative;
		logic [6:0] esls_index;
	} out_item_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ESLS_W-1:0] esls;
		logic [2:0]        route_id;
		logic              route_up;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_head_t;

	typedef enum logic [3:0] {
		BK_IDLE  = 4'b0001,
		BK_EVAL  = 4'b0010,
		BK_SWEEP = 4'b0100,
		BK_FIN   = 4'b1000
	} bk_state_t;

endpackage

@@ rtl/sls_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sls_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/sls_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_front: configuration registers, word classification and queue
// Computes the extended SLS of each word and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module sls_front import sls_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output q_head_t           head,
	input  logic              pop
);

	logic [SHIFT_W-1:0]  opc_sh_q;
	logic [SHIFT_W-1:0]  dpc_sh_q;
	logic [ESHIFT_W-1:0] esls_sh_q;
	logic [5:0]          o6, d6;
	logic [2:0]          o3, d3;
	q_item_t             cls;
	q_item_t             fifo_q [2];
	logic                wr_ptr_q, rd_ptr_q;
	logic [1:0]          cnt_q;
	logic                push;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opc_sh_q  <= '0;
			dpc_sh_q  <= '0;
			esls_sh_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_OPC_SHIFT:  opc_sh_q  <= pwdata[SHIFT_W-1:0];
				REG_DPC_SHIFT:  dpc_sh_q  <= pwdata[SHIFT_W-1:0];
				REG_ESLS_SHIFT: esls_sh_q <= pwdata[ESHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_OPC_SHIFT:  prdata = {27'd0, opc_sh_q};
			REG_DPC_SHIFT:  prdata = {27'd0, dpc_sh_q};
			REG_ESLS_SHIFT: prdata = {29'd0, esls_sh_q};
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		o6 = 6'(in_item.origin_code >> opc_sh_q) & SIX_MASK;
		d6 = 6'(in_item.dest_code >> dpc_sh_q) & SIX_MASK;
		o3 = o6[5:3] ^ o6[2:0];
		d3 = d6[5:3] ^ d6[2:0];
		cls.cmd      = in_item.cmd;
		cls.esls     = {o3 ^ d3, in_item.link_selection} >> esls_sh_q;
		cls.route_id = in_item.route_id;
		cls.route_up = in_item.route_up;
	end

	assign in_stall   = cnt_q[1];
	assign push       = in_valid && !in_stall;
	assign head.valid = cnt_q != 2'd0;
	assign head.item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ rtl/sls_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_back: route table, sticky choices and round-robin selection
// Executes queued words and holds the result register.
// ----------------------------------------------------------------------------
module sls_back import sls_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_head_t   head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	localparam int RAM_W = 2 * ROUTE_W;

	bk_state_t            state_q;
	q_item_t              cur_q;
	logic [ROUTE_W-1:0]   order_q [MAX_ROUTES];
	logic [COUNT_W-1:0]   count_q;
	logic [MAX_ROUTES-1:0] present_q, avail_q;
	logic                 rr_v_q;
	logic [ROUTE_W-1:0]   rr_id_q;
	logic [ESLS_ENTRIES-1:0] nvld_q, avld_q;
	logic [ROUTE_W-1:0]   del_q;
	logic [ESLS_W:0]      swp_q;
	logic                 sv_s1;
	logic [ESLS_W-1:0]    sa_s1;
	logic                 out_v_q;
	out_item_t            out_q;

	logic                 ram_we, ram_re;
	logic [ESLS_W-1:0]    ram_waddr, ram_raddr;
	logic [RAM_W-1:0]     ram_wdata, ram_rdata;
	logic [ROUTE_W-1:0]   nr, ar;

	logic                 out_free;
	logic [ROUTE_W-1:0]   rr_pos, del_pos, start;
	logic [COUNT_W-1:0]   idx;
	logic                 rr_hit;
	logic [ROUTE_W-1:0]   rr_win;
	logic                 rr_nv;
	logic [ROUTE_W-1:0]   rr_nid;
	logic                 nv, av, un, ua;
	logic                 ev_found, ev_alt, set_n, set_a, clr_a, use_rr;
	logic [ROUTE_W-1:0]   ev_route;
	logic [ROUTE_W-1:0]   hid;
	logic                 hpres;
	logic [1:0]           cmd_st;
	logic                 out_load;

	sls_ram #(.WIDTH(RAM_W), .DEPTH(ESLS_ENTRIES)) u_choice_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign nr       = ram_rdata[RAM_W-1:ROUTE_W];
	assign ar       = ram_rdata[ROUTE_W-1:0];
	assign out_free = !out_v_q || !out_stall;
	assign pop      = (state_q == BK_IDLE) && head.valid && out_free;
	assign hid      = head.item.route_id;
	assign hpres    = present_q[hid];
	assign out_valid = out_v_q;
	assign out_item  = out_q;

	always_comb begin
		rr_pos  = '0;
		del_pos = '0;
		for (int i = MAX_ROUTES - 1; i >= 0; i--) begin
			if (COUNT_W'(i) < count_q && order_q[i] == rr_id_q) begin
				rr_pos = ROUTE_W'(i);
			end
			if (COUNT_W'(i) < count_q && order_q[i] == hid) begin
				del_pos = ROUTE_W'(i);
			end
		end
		if (rr_v_q && ({1'b0, rr_pos} + COUNT_W'(1)) < count_q) begin
			start = rr_pos + ROUTE_W'(1);
		end else begin
			start = '0;
		end
		rr_hit = 1'b0;
		rr_win = '0;
		for (int k = 0; k < MAX_ROUTES; k++) begin
			idx = {1'b0, start} + COUNT_W'(k);
			if (idx >= count_q) begin
				idx = idx - count_q;
			end
			if (!rr_hit && COUNT_W'(k) < count_q && avail_q[order_q[idx[ROUTE_W-1:0]]]) begin
				rr_hit = 1'b1;
				rr_win = order_q[idx[ROUTE_W-1:0]];
			end
		end
		if (count_q == '0) begin
			rr_nv  = rr_v_q;
			rr_nid = rr_id_q;
		end else if (rr_hit) begin
			rr_nv  = 1'b1;
			rr_nid = rr_win;
		end else if (rr_v_q) begin
			rr_nv  = 1'b1;
			rr_nid = rr_id_q;
		end else begin
			rr_nv  = 1'b1;
			rr_nid = order_q[ROUTE_W'(count_q - COUNT_W'(1))];
		end
	end

	always_comb begin
		nv       = nvld_q[cur_q.esls];
		av       = avld_q[cur_q.esls];
		un       = nv && avail_q[nr];
		ua       = av && avail_q[ar];
		ev_found = 1'b0;
		ev_alt   = 1'b0;
		ev_route = '0;
		set_n    = 1'b0;
		set_a    = 1'b0;
		clr_a    = 1'b0;
		use_rr   = 1'b0;
		priority if (un) begin
			ev_found = 1'b1;
			ev_route = nr;
			clr_a    = 1'b1;
		end else if (ua) begin
			ev_found = 1'b1;
			ev_route = ar;
			ev_alt   = 1'b1;
		end else if (!nv) begin
			use_rr   = 1'b1;
			ev_found = rr_hit;
			ev_route = rr_hit ? rr_win : '0;
			set_n    = rr_hit;
		end else begin
			use_rr   = 1'b1;
			ev_found = rr_hit;
			ev_route = rr_hit ? rr_win : '0;
			ev_alt   = rr_hit;
			set_a    = rr_hit;
		end
	end

	always_comb begin
		cmd_st = ST_OK;
		unique case (head.item.cmd)
			CMD_LOOKUP: begin
				cmd_st = ST_OK;
			end
			CMD_ADD: begin
				if (hpres || count_q >= COUNT_W'(MAX_ROUTES)) begin
					cmd_st = ST_REFUSED;
				end
			end
			default: begin
				if (!hpres) begin
					cmd_st = ST_ABSENT;
				end
			end
		endcase
		unique case (state_q)
			BK_IDLE: begin
				out_load = pop && head.item.cmd != CMD_LOOKUP
					&& !(head.item.cmd == CMD_DELETE && hpres);
			end
			BK_EVAL, BK_FIN: begin
				out_load = out_free;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = head.item.esls;
		if (pop && head.item.cmd == CMD_LOOKUP) begin
			ram_re = 1'b1;
		end else if (state_q == BK_SWEEP && !swp_q[ESLS_W]) begin
			ram_re    = 1'b1;
			ram_raddr = swp_q[ESLS_W-1:0];
		end
		ram_we    = (state_q == BK_EVAL) && out_free && (set_n || set_a);
		ram_waddr = cur_q.esls;
		ram_wdata = set_n ? {rr_win, ar} : {nr, rr_win};
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.item;
			if (head.item.cmd == CMD_ADD && !hpres && count_q < COUNT_W'(MAX_ROUTES)) begin
				order_q[count_q[ROUTE_W-1:0]] <= hid;
			end
			if (head.item.cmd == CMD_DELETE && hpres) begin
				del_q <= hid;
				for (int i = 0; i < MAX_ROUTES - 1; i++) begin
					if (ROUTE_W'(i) >= del_pos && COUNT_W'(i + 1) < count_q) begin
						order_q[i] <= order_q[i + 1];
					end
				end
			end
		end
		sa_s1 <= swp_q[ESLS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			count_q   <= '0;
			present_q <= '0;
			avail_q   <= '0;
			rr_v_q    <= 1'b0;
			rr_id_q   <= '0;
			nvld_q    <= '0;
			avld_q    <= '0;
			swp_q     <= '0;
			sv_s1     <= 1'b0;
			out_v_q   <= 1'b0;
			out_q     <= '0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			sv_s1 <= (state_q == BK_SWEEP) && !swp_q[ESLS_W];
			unique case (state_q)
				BK_IDLE: begin
					if (pop) begin
						out_q <= '{status: cmd_st, default: '0};
						unique case (head.item.cmd)
							CMD_LOOKUP: begin
								state_q <= BK_EVAL;
							end
							CMD_ADD: begin
								if (cmd_st == ST_OK) begin
									count_q        <= count_q + COUNT_W'(1);
									present_q[hid] <= 1'b1;
									avail_q[hid]   <= 1'b0;
								end
							end
							CMD_AVAIL: begin
								if (hpres) begin
									avail_q[hid] <= head.item.route_up;
								end
							end
							default: begin
								if (hpres) begin
									if (rr_v_q && rr_id_q == hid) begin
										if (order_q[start] == hid) begin
											rr_v_q <= 1'b0;
										end else begin
											rr_id_q <= order_q[start];
										end
									end
									count_q        <= count_q - COUNT_W'(1);
									present_q[hid] <= 1'b0;
									avail_q[hid]   <= 1'b0;
									swp_q          <= '0;
									state_q        <= BK_SWEEP;
								end
							end
						endcase
					end
				end
				BK_EVAL: begin
					if (out_free) begin
						out_q.status          <= ST_OK;
						out_q.route_found     <= ev_found;
						out_q.chosen_route    <= ev_route;
						out_q.via_alternative <= ev_alt;
						out_q.esls_index      <= cur_q.esls;
						if (use_rr) begin
							rr_v_q  <= rr_nv;
							rr_id_q <= rr_nid;
						end
						if (set_n) begin
							nvld_q[cur_q.esls] <= 1'b1;
						end
						if (set_a) begin
							avld_q[cur_q.esls] <= 1'b1;
						end
						if (clr_a) begin
							avld_q[cur_q.esls] <= 1'b0;
						end
						state_q <= BK_IDLE;
					end
				end
				BK_SWEEP: begin
					if (!swp_q[ESLS_W]) begin
						swp_q <= swp_q + (ESLS_W+1)'(1);
					end
					if (sv_s1) begin
						if (nr == del_q) begin
							nvld_q[sa_s1] <= 1'b0;
						end
						if (ar == del_q) begin
							avld_q[sa_s1] <= 1'b0;
						end
						if (sa_s1 == ESLS_W'(ESLS_ENTRIES - 1)) begin
							state_q <= BK_FIN;
						end
					end
				end
				BK_FIN: begin
					if (out_free) begin
						out_q   <= '0;
						state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/sls_sticky_route_selector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_sticky_route_selector_unit: load-sharing route selector
// Sticky per-extended-SLS normal and alternative routes with round-robin
// fallback, plus route add, delete and availability commands.
//
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  in_item (in_item_t)
// out       output     out_valid/out_stall out_item (out_item_t)
// config    input      APB write/read     opc, dpc and eSLS shifts
//
// A lookup first reads the choice RAM, then decides in the evaluate state.
// Add and availability words are completed when they are taken from the queue.
// A delete sweeps all 128 choice entries through the RAM read port before
// its word is returned.
// Reset clears the route set, round-robin pointer and all choice valid bits.
// A two-entry queue lets input be taken while the output register stalls.
// ----------------------------------------------------------------------------
module sls_sticky_route_selector_unit import sls_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	q_head_t head;
	logic    pop;

	sls_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.head     (head),
		.pop      (pop)
	);

	sls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

@@ rtl/sls_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_checker: port-level checks of the route selector
// Output channel behaviour and consistency of result words.
// ----------------------------------------------------------------------------
module sls_checker import sls_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result word changed");

	a_status_no_route: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_OK |-> !out_item.route_found
			&& out_item.esls_index == '0)
		else $error("command word carries lookup fields");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.route_found |-> out_item.chosen_route == '0
			&& !out_item.via_alternative)
		else $error("route reported without a find");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status <= ST_ABSENT)
		else $error("undefined status code");

endmodule

bind sls_sticky_route_selector_unit sls_checker u_sls_checker (.*);
